// ===== src/assert_macros.svh =====
// Assertion macros shared by the triangle closest-point RTL.
// Each macro expands to one labelled concurrent assertion on the rising clock edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define TCP_ASSERT(lbl, clk_i, rstn_i, prop, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) prop) else $error(msg);

// The condition must never be true outside reset.
`define TCP_ASSERT_NEVER(lbl, clk_i, rstn_i, cond, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) !(cond)) else $error(msg);

`endif

// ===== src/tcp_pkg.sv =====
// Shared types, defaults and width helpers for the triangle closest-point block.
// Used by tcp_fifo, tcp_front, tcp_back and the top level; depends on nothing.
`default_nettype none

package tcp_pkg;

	localparam int COORD_WIDTH_DEF      = 24;
	localparam int WEIGHT_FRAC_BITS_DEF = 16;
	localparam int QUEUE_DEPTH          = 4;

	// Region codes, in the order the tests are made.
	typedef enum logic [2:0] {
		REG_VERT_A = 3'd0,
		REG_VERT_B = 3'd1,
		REG_EDGE_AB = 3'd2,
		REG_VERT_C = 3'd3,
		REG_EDGE_AC = 3'd4,
		REG_EDGE_BC = 3'd5,
		REG_INTERIOR = 3'd6
	} region_t;

	typedef struct packed {
		region_t region;
		logic    degen;
	} ctl_t;

	// Width of the divisor word for a given coordinate width: two levels of
	// exact products plus the three-term sum of the interior divisor.
	function automatic int den_w(input int cw);
		return 4 * cw + 11;
	endfunction

endpackage

`default_nettype wire

// ===== src/tcp_fifo.sv =====
// Short register queue that decouples the classifying front from the solving back.
// Generic payload vector; takes tcp_pkg for its default depth and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tcp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = tcp_pkg::QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             rd,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr, do_rd;
	logic [CNT_W-1:0] cnt_inc, cnt_dec;

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Expected count after a lone write or a lone read.
	assign cnt_inc = cnt_q + 1'b1;
	assign cnt_dec = cnt_q - 1'b1;

	`TCP_ASSERT_NEVER(a_cnt_range, clk, arst_n, cnt_q > CNT_W'(DEPTH), "queue count above depth")
	`TCP_ASSERT(a_cnt_grow, clk, arst_n, (do_wr && !do_rd) |=> (cnt_q == $past(cnt_inc)), "count not raised")
	`TCP_ASSERT(a_cnt_shrink, clk, arst_n, (do_rd && !do_wr) |=> (cnt_q == $past(cnt_dec)), "count not lowered")

endmodule

`default_nettype wire

// ===== src/tcp_front.sv =====
// Front end: takes triangles, forms the exact dot products and region determinants,
// picks the Voronoi region and the divisor. Depends on tcp_pkg.
`default_nettype none

module tcp_front #(
	parameter int COORD_WIDTH = tcp_pkg::COORD_WIDTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     push,
	output logic                          full,
	input  wire logic [COORD_WIDTH-1:0]   a_x,
	input  wire logic [COORD_WIDTH-1:0]   a_y,
	input  wire logic [COORD_WIDTH-1:0]   a_z,
	input  wire logic [COORD_WIDTH-1:0]   b_x,
	input  wire logic [COORD_WIDTH-1:0]   b_y,
	input  wire logic [COORD_WIDTH-1:0]   b_z,
	input  wire logic [COORD_WIDTH-1:0]   c_x,
	input  wire logic [COORD_WIDTH-1:0]   c_y,
	input  wire logic [COORD_WIDTH-1:0]   c_z,
	output logic                          q_push,
	input  wire logic                     q_full,
	output tcp_pkg::ctl_t                 q_ctl,
	output logic [9*COORD_WIDTH-1:0]      q_tri,
	output logic [tcp_pkg::den_w(COORD_WIDTH)-1:0] q_num0,
	output logic [tcp_pkg::den_w(COORD_WIDTH)-1:0] q_num1,
	output logic [tcp_pkg::den_w(COORD_WIDTH)-1:0] q_den
);

	localparam int CW      = COORD_WIDTH;
	localparam int DIFF_W  = CW + 1;
	localparam int PROD_W  = 2 * DIFF_W;
	localparam int DOT_W   = PROD_W + 2;
	localparam int HALF    = (DOT_W + 1) / 2;
	localparam int HI_W    = DOT_W - HALF;
	localparam int HH_W    = 2 * HI_W;
	localparam int HL_W    = HI_W + HALF + 1;
	localparam int LL_W    = 2 * HALF;
	localparam int VPROD_W = 2 * DOT_W;
	localparam int V_W     = VPROD_W + 1;
	localparam int E_W     = DOT_W + 1;
	localparam int DEN_W   = tcp_pkg::den_w(CW);

	// Operand pairs of the six determinant products: d1*d4, d3*d2, d5*d2,
	// d1*d6, d3*d6, d5*d4 (dot products numbered from one here).
	localparam int PX [6] = '{0, 2, 4, 0, 2, 4};
	localparam int PY [6] = '{3, 1, 1, 5, 5, 3};

	logic fe;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic [9*CW-1:0] tri_s1, tri_s2, tri_s3, tri_s4, tri_s5, tri_s6, tri_s7;

	logic signed [PROD_W-1:0] prod_c [6][3];
	logic signed [PROD_W-1:0] prod_s2 [6][3];
	logic signed [DOT_W-1:0]  d_c [6];
	logic signed [DOT_W-1:0]  d_s3 [6], d_s4 [6], d_s5 [6], d_s6 [6];
	logic signed [HH_W-1:0]   hh_c [6], hh_s4 [6];
	logic signed [HL_W-1:0]   hl_c [6], hl_s4 [6], lh_c [6], lh_s4 [6];
	logic [LL_W-1:0]          ll_c [6], ll_s4 [6];
	logic signed [VPROD_W-1:0] vp_c [6], vp_s5 [6];
	logic signed [V_W-1:0]    va_s6, vb_s6, vc_s6;
	logic signed [E_W-1:0]    e1_s6, e2_s6;

	tcp_pkg::ctl_t     ctl_c, ctl_s7;
	logic [DEN_W-1:0]  num0_c, num1_c, den_c;
	logic [DEN_W-1:0]  num0_s7, num1_s7, den_s7;
	logic signed [DEN_W-1:0] den_sel;
	logic              needs_div;

	// The pipeline moves unless a finished item is waiting on a full queue.
	assign fe     = !(v_s7 && q_full);
	assign full   = !fe;
	assign q_push = v_s7 && !q_full;
	assign q_ctl  = ctl_s7;
	assign q_tri  = tri_s7;
	assign q_num0 = num0_s7;
	assign q_num1 = num1_s7;
	assign q_den  = den_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (fe) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// Edge vectors, negated vertices and the eighteen coordinate products.
	always_comb begin
		logic signed [DIFF_W-1:0] ab_c [3];
		logic signed [DIFF_W-1:0] ac_c [3];
		logic signed [DIFF_W-1:0] n_c [3][3];
		for (int k = 0; k < 3; k++) begin
			ab_c[k] = DIFF_W'($signed(tri_s1[(3 + k) * CW +: CW]))
				- DIFF_W'($signed(tri_s1[k * CW +: CW]));
			ac_c[k] = DIFF_W'($signed(tri_s1[(6 + k) * CW +: CW]))
				- DIFF_W'($signed(tri_s1[k * CW +: CW]));
			for (int v = 0; v < 3; v++) begin
				n_c[v][k] = -DIFF_W'($signed(tri_s1[(3 * v + k) * CW +: CW]));
			end
			for (int v = 0; v < 3; v++) begin
				prod_c[2 * v][k]     = PROD_W'(ab_c[k]) * PROD_W'(n_c[v][k]);
				prod_c[2 * v + 1][k] = PROD_W'(ac_c[k]) * PROD_W'(n_c[v][k]);
			end
		end
	end

	always_comb begin
		for (int j = 0; j < 6; j++) begin
			d_c[j] = DOT_W'(prod_s2[j][0]) + DOT_W'(prod_s2[j][1]) + DOT_W'(prod_s2[j][2]);
		end
	end

	// Determinant products are split into half-width partial products.
	always_comb begin
		logic [HALF-1:0]        xl, yl;
		logic signed [HI_W-1:0] xh, yh;
		for (int i = 0; i < 6; i++) begin
			xl = d_s3[PX[i]][HALF-1:0];
			yl = d_s3[PY[i]][HALF-1:0];
			xh = $signed(d_s3[PX[i]][DOT_W-1:HALF]);
			yh = $signed(d_s3[PY[i]][DOT_W-1:HALF]);
			hh_c[i] = HH_W'(xh) * HH_W'(yh);
			hl_c[i] = HL_W'(xh) * HL_W'($signed({1'b0, yl}));
			lh_c[i] = HL_W'(yh) * HL_W'($signed({1'b0, xl}));
			ll_c[i] = LL_W'(xl) * LL_W'(yl);
		end
	end

	always_comb begin
		for (int i = 0; i < 6; i++) begin
			vp_c[i] = (VPROD_W'(hh_s4[i]) << (2 * HALF))
				+ (VPROD_W'(hl_s4[i]) << HALF)
				+ (VPROD_W'(lh_s4[i]) << HALF)
				+ VPROD_W'(ll_s4[i]);
		end
	end

	// Region tests in the classic order; the first that accepts wins.
	always_comb begin
		ctl_c.region = tcp_pkg::REG_VERT_A;
		ctl_c.degen  = 1'b0;
		num0_c       = '0;
		num1_c       = '0;
		den_sel      = '0;
		needs_div    = 1'b0;
		priority if (d_s6[0] <= 0 && d_s6[1] <= 0) begin
			ctl_c.region = tcp_pkg::REG_VERT_A;
		end else if (d_s6[2] >= 0 && e1_s6 <= 0) begin
			ctl_c.region = tcp_pkg::REG_VERT_B;
		end else if (vc_s6 <= 0 && d_s6[0] >= 0 && d_s6[2] <= 0) begin
			ctl_c.region = tcp_pkg::REG_EDGE_AB;
			den_sel      = DEN_W'(d_s6[0]) - DEN_W'(d_s6[2]);
			num0_c       = DEN_W'(d_s6[0]);
			needs_div    = 1'b1;
		end else if (d_s6[5] >= 0 && e2_s6 <= 0) begin
			ctl_c.region = tcp_pkg::REG_VERT_C;
		end else if (vb_s6 <= 0 && d_s6[1] >= 0 && d_s6[5] <= 0) begin
			ctl_c.region = tcp_pkg::REG_EDGE_AC;
			den_sel      = DEN_W'(d_s6[1]) - DEN_W'(d_s6[5]);
			num0_c       = DEN_W'(d_s6[1]);
			needs_div    = 1'b1;
		end else if (va_s6 <= 0 && e1_s6 >= 0 && e2_s6 >= 0) begin
			ctl_c.region = tcp_pkg::REG_EDGE_BC;
			den_sel      = DEN_W'(e1_s6) + DEN_W'(e2_s6);
			num0_c       = DEN_W'(e1_s6);
			needs_div    = 1'b1;
		end else begin
			ctl_c.region = tcp_pkg::REG_INTERIOR;
			den_sel      = DEN_W'(va_s6) + DEN_W'(vb_s6) + DEN_W'(vc_s6);
			num0_c       = DEN_W'(vb_s6);
			num1_c       = DEN_W'(vc_s6);
			needs_div    = 1'b1;
		end
		den_c = den_sel;
		// A zero or negative divisor falls back to vertex a.
		if (needs_div && den_sel <= 0) begin
			ctl_c.region = tcp_pkg::REG_VERT_A;
			ctl_c.degen  = 1'b1;
			num0_c       = '0;
			num1_c       = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (fe) begin
			tri_s1  <= {c_z, c_y, c_x, b_z, b_y, b_x, a_z, a_y, a_x};
			tri_s2  <= tri_s1;
			tri_s3  <= tri_s2;
			tri_s4  <= tri_s3;
			tri_s5  <= tri_s4;
			tri_s6  <= tri_s5;
			tri_s7  <= tri_s6;
			prod_s2 <= prod_c;
			d_s3    <= d_c;
			d_s4    <= d_s3;
			hh_s4   <= hh_c;
			hl_s4   <= hl_c;
			lh_s4   <= lh_c;
			ll_s4   <= ll_c;
			d_s5    <= d_s4;
			vp_s5   <= vp_c;
			d_s6    <= d_s5;
			vc_s6   <= V_W'(vp_s5[0]) - V_W'(vp_s5[1]);
			vb_s6   <= V_W'(vp_s5[2]) - V_W'(vp_s5[3]);
			va_s6   <= V_W'(vp_s5[4]) - V_W'(vp_s5[5]);
			e1_s6   <= E_W'(d_s5[3]) - E_W'(d_s5[2]);
			e2_s6   <= E_W'(d_s5[4]) - E_W'(d_s5[5]);
			ctl_s7  <= ctl_c;
			num0_s7 <= num0_c;
			num1_s7 <= num1_c;
			den_s7  <= den_c;
		end
	end

endmodule

`default_nettype wire

// ===== src/tcp_back.sv =====
// Back end: pipelined restoring division for the weights, then the weighted point.
// Depends on tcp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tcp_back #(
	parameter int COORD_WIDTH      = tcp_pkg::COORD_WIDTH_DEF,
	parameter int WEIGHT_FRAC_BITS = tcp_pkg::WEIGHT_FRAC_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      q_empty,
	output logic                           q_pop,
	input  wire tcp_pkg::ctl_t             q_ctl,
	input  wire logic [9*COORD_WIDTH-1:0]  q_tri,
	input  wire logic [tcp_pkg::den_w(COORD_WIDTH)-1:0] q_num0,
	input  wire logic [tcp_pkg::den_w(COORD_WIDTH)-1:0] q_num1,
	input  wire logic [tcp_pkg::den_w(COORD_WIDTH)-1:0] q_den,
	output logic                           empty,
	input  wire logic                      pop,
	output logic [COORD_WIDTH-1:0]         near_x,
	output logic [COORD_WIDTH-1:0]         near_y,
	output logic [COORD_WIDTH-1:0]         near_z,
	output logic [WEIGHT_FRAC_BITS:0]      weight_a,
	output logic [WEIGHT_FRAC_BITS:0]      weight_b,
	output logic [WEIGHT_FRAC_BITS:0]      weight_c,
	output logic [2:0]                     region,
	output logic                           degenerate
);

	localparam int CW     = COORD_WIDTH;
	localparam int F      = WEIGHT_FRAC_BITS;
	localparam int DIFF_W = CW + 1;
	localparam int DEN_W  = tcp_pkg::den_w(CW);
	localparam int WT_W   = F + 1;
	localparam int MP_W   = WT_W + 1 + DIFF_W;
	localparam int SUM_W  = MP_W + 1;
	localparam logic [WT_W-1:0] W_ONE = {1'b1, {F{1'b0}}};

	logic be;

	// Divider stages: index 0 is the entry stage, index i has i quotient bits.
	logic              v_s   [0:F];
	logic [DEN_W-1:0]  rem_s [0:F][2];
	logic [F-1:0]      quo_s [0:F][2];
	logic              zero_s [0:F][2];
	logic              one_s  [0:F][2];
	logic [DEN_W-1:0]  den_s [0:F];
	tcp_pkg::ctl_t     ctl_s [0:F];
	logic [9*CW-1:0]   tri_s [0:F];

	// Weight stage, multiply stage, output register.
	logic                     v_sw, v_sm, v_q;
	tcp_pkg::ctl_t            ctl_sw, ctl_sm, ctl_q;
	logic [WT_W-1:0]          wa_sw, wb_sw, wc_sw, wa_sm, wb_sm, wc_sm;
	logic [WT_W-1:0]          t0_sw, t1_sw;
	logic [3*CW-1:0]          base_sw, base_sm;
	logic signed [DIFF_W-1:0] d0_sw [3], d1_sw [3];
	logic signed [MP_W-1:0]   m0_sm [3], m1_sm [3];
	logic [3*CW-1:0]          near_q;
	logic [WT_W-1:0]          wa_q, wb_q, wc_q;

	logic [WT_W-1:0]          wa_c, wb_c, wc_c, t0_c, t1_c;
	logic [3*CW-1:0]          base_c;
	logic signed [DIFF_W-1:0] d0_c [3], d1_c [3];
	logic [3*CW-1:0]          near_c;
	logic [WT_W-1:0]          tq [2];

	logic [WT_W+1:0]          w_sum;
	logic                     degen_at_a;

	assign be    = !v_q || pop;
	assign q_pop = be && !q_empty;
	assign empty = !v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= F; i++) begin
				v_s[i] <= 1'b0;
			end
			v_sw <= 1'b0;
			v_sm <= 1'b0;
			v_q  <= 1'b0;
		end else if (be) begin
			v_s[0] <= !q_empty;
			for (int i = 1; i <= F; i++) begin
				v_s[i] <= v_s[i - 1];
			end
			v_sw <= v_s[F];
			v_sm <= v_sw;
			v_q  <= v_sm;
		end
	end

	// Entry: saturation tests, remainder starts at the numerator.
	always_ff @(posedge clk) begin
		if (be) begin
			zero_s[0][0] <= $signed(q_num0) <= 0;
			zero_s[0][1] <= $signed(q_num1) <= 0;
			one_s[0][0]  <= ($signed(q_num0) > 0) && ($signed(q_den) <= $signed(q_num0));
			one_s[0][1]  <= ($signed(q_num1) > 0) && ($signed(q_den) <= $signed(q_num1));
			rem_s[0][0]  <= q_num0;
			rem_s[0][1]  <= q_num1;
			quo_s[0][0]  <= '0;
			quo_s[0][1]  <= '0;
			den_s[0]     <= q_den;
			ctl_s[0]     <= q_ctl;
			tri_s[0]     <= q_tri;
		end
	end

	// One quotient bit per stage for both lanes.
	for (genvar i = 1; i <= F; i++) begin : g_step
		logic [DEN_W-1:0] r2 [2];
		logic             ge [2];

		always_comb begin
			for (int l = 0; l < 2; l++) begin
				r2[l] = {rem_s[i - 1][l][DEN_W-2:0], 1'b0};
				ge[l] = (r2[l] >= den_s[i - 1]);
			end
		end

		always_ff @(posedge clk) begin
			if (be) begin
				for (int l = 0; l < 2; l++) begin
					rem_s[i][l]  <= ge[l] ? r2[l] - den_s[i - 1] : r2[l];
					quo_s[i][l]  <= {quo_s[i - 1][l][F-2:0], ge[l]};
					zero_s[i][l] <= zero_s[i - 1][l];
					one_s[i][l]  <= one_s[i - 1][l];
				end
				den_s[i] <= den_s[i - 1];
				ctl_s[i] <= ctl_s[i - 1];
				tri_s[i] <= tri_s[i - 1];
			end
		end
	end

	// Weights, start point and direction vectors by region.
	always_comb begin
		logic [WT_W:0]   vw_sum;
		logic [WT_W-1:0] w_cut;
		for (int l = 0; l < 2; l++) begin
			if (one_s[F][l]) begin
				tq[l] = W_ONE;
			end else if (zero_s[F][l]) begin
				tq[l] = '0;
			end else begin
				tq[l] = {1'b0, quo_s[F][l]};
			end
		end
		vw_sum = (WT_W + 1)'(tq[0]) + (WT_W + 1)'(tq[1]);
		w_cut  = (vw_sum > (WT_W + 1)'(W_ONE)) ? W_ONE - tq[0] : tq[1];
		wa_c   = W_ONE;
		wb_c   = '0;
		wc_c   = '0;
		t0_c   = '0;
		t1_c   = '0;
		base_c = tri_s[F][0 +: 3 * CW];
		for (int k = 0; k < 3; k++) begin
			d0_c[k] = '0;
			d1_c[k] = '0;
		end
		unique case (ctl_s[F].region)
			tcp_pkg::REG_VERT_A: begin
				wa_c = W_ONE;
			end
			tcp_pkg::REG_VERT_B: begin
				wa_c   = '0;
				wb_c   = W_ONE;
				base_c = tri_s[F][3 * CW +: 3 * CW];
			end
			tcp_pkg::REG_VERT_C: begin
				wa_c   = '0;
				wc_c   = W_ONE;
				base_c = tri_s[F][6 * CW +: 3 * CW];
			end
			tcp_pkg::REG_EDGE_AB: begin
				wa_c = W_ONE - tq[0];
				wb_c = tq[0];
				t0_c = tq[0];
				for (int k = 0; k < 3; k++) begin
					d0_c[k] = DIFF_W'($signed(tri_s[F][(3 + k) * CW +: CW]))
						- DIFF_W'($signed(tri_s[F][k * CW +: CW]));
				end
			end
			tcp_pkg::REG_EDGE_AC: begin
				wa_c = W_ONE - tq[0];
				wc_c = tq[0];
				t0_c = tq[0];
				for (int k = 0; k < 3; k++) begin
					d0_c[k] = DIFF_W'($signed(tri_s[F][(6 + k) * CW +: CW]))
						- DIFF_W'($signed(tri_s[F][k * CW +: CW]));
				end
			end
			tcp_pkg::REG_EDGE_BC: begin
				wa_c   = '0;
				wb_c   = W_ONE - tq[0];
				wc_c   = tq[0];
				t0_c   = tq[0];
				base_c = tri_s[F][3 * CW +: 3 * CW];
				for (int k = 0; k < 3; k++) begin
					d0_c[k] = DIFF_W'($signed(tri_s[F][(6 + k) * CW +: CW]))
						- DIFF_W'($signed(tri_s[F][(3 + k) * CW +: CW]));
				end
			end
			tcp_pkg::REG_INTERIOR: begin
				wa_c = W_ONE - tq[0] - w_cut;
				wb_c = tq[0];
				wc_c = w_cut;
				t0_c = tq[0];
				t1_c = w_cut;
				for (int k = 0; k < 3; k++) begin
					d0_c[k] = DIFF_W'($signed(tri_s[F][(3 + k) * CW +: CW]))
						- DIFF_W'($signed(tri_s[F][k * CW +: CW]));
					d1_c[k] = DIFF_W'($signed(tri_s[F][(6 + k) * CW +: CW]))
						- DIFF_W'($signed(tri_s[F][k * CW +: CW]));
				end
			end
			default: begin
				wa_c = W_ONE;
			end
		endcase
	end

	// Floor of the weighted offset is an arithmetic shift of the sum.
	always_comb begin
		logic signed [SUM_W-1:0] acc;
		logic signed [SUM_W-1:0] off;
		for (int k = 0; k < 3; k++) begin
			acc = SUM_W'(m0_sm[k]) + SUM_W'(m1_sm[k]);
			off = acc >>> F;
			near_c[k * CW +: CW] = CW'(SUM_W'($signed(base_sm[k * CW +: CW])) + off);
		end
	end

	always_ff @(posedge clk) begin
		if (be) begin
			ctl_sw  <= ctl_s[F];
			wa_sw   <= wa_c;
			wb_sw   <= wb_c;
			wc_sw   <= wc_c;
			t0_sw   <= t0_c;
			t1_sw   <= t1_c;
			base_sw <= base_c;
			d0_sw   <= d0_c;
			d1_sw   <= d1_c;
			ctl_sm  <= ctl_sw;
			wa_sm   <= wa_sw;
			wb_sm   <= wb_sw;
			wc_sm   <= wc_sw;
			base_sm <= base_sw;
			for (int k = 0; k < 3; k++) begin
				m0_sm[k] <= MP_W'($signed({1'b0, t0_sw})) * MP_W'(d0_sw[k]);
				m1_sm[k] <= MP_W'($signed({1'b0, t1_sw})) * MP_W'(d1_sw[k]);
			end
			ctl_q  <= ctl_sm;
			wa_q   <= wa_sm;
			wb_q   <= wb_sm;
			wc_q   <= wc_sm;
			near_q <= near_c;
		end
	end

	assign near_x     = near_q[0 +: CW];
	assign near_y     = near_q[CW +: CW];
	assign near_z     = near_q[2 * CW +: CW];
	assign weight_a   = wa_q;
	assign weight_b   = wb_q;
	assign weight_c   = wc_q;
	assign region     = ctl_q.region;
	assign degenerate = ctl_q.degen;

	// Terms for the result checks below.
	assign w_sum      = (WT_W + 2)'(wa_q) + (WT_W + 2)'(wb_q) + (WT_W + 2)'(wc_q);
	assign degen_at_a = (ctl_q.region == tcp_pkg::REG_VERT_A) && (wa_q == W_ONE);

	`TCP_ASSERT(a_weight_sum, clk, arst_n, v_q |-> (w_sum == (WT_W + 2)'(W_ONE)), "weights not one")
	`TCP_ASSERT(a_degen_vertex, clk, arst_n, (v_q && ctl_q.degen) |-> degen_at_a, "degenerate off a")
	`TCP_ASSERT_NEVER(a_weight_range, clk, arst_n, v_q && (wa_q > W_ONE), "weight a above one")

endmodule

`default_nettype wire

// ===== src/triangle_closest_point_to_origin.sv =====
// Top level of the triangle closest-point block: front, queue and back joined.
// Depends on tcp_pkg, tcp_front, tcp_fifo and tcp_back.
//
//   Channel   Handshake        Payload
//   triangle  push / full      a_x a_y a_z b_x b_y b_z c_x c_y c_z
//   result    pop / empty      near_x near_y near_z weight_a weight_b weight_c
//                              region degenerate
//
// The block takes one triangle in every clock cycle while full is low and gives one result for each.
// The path runs through 7 front stages, at least one queue slot, WEIGHT_FRAC_BITS + 1
// divider stages and 3 point stages; the restoring divider, one quotient bit per stage,
// sets the depth.
// Reset (arst_n low) empties every stage and the queue; payload is not cleared.
// When the result is not taken, the back holds and the queue fills; once it is
// full the front holds and full is raised, so no transfer is lost or repeated.
`default_nettype none

module triangle_closest_point_to_origin #(
	parameter int COORD_WIDTH      = tcp_pkg::COORD_WIDTH_DEF,
	parameter int WEIGHT_FRAC_BITS = tcp_pkg::WEIGHT_FRAC_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	output logic                        full,
	input  wire logic [COORD_WIDTH-1:0] a_x,
	input  wire logic [COORD_WIDTH-1:0] a_y,
	input  wire logic [COORD_WIDTH-1:0] a_z,
	input  wire logic [COORD_WIDTH-1:0] b_x,
	input  wire logic [COORD_WIDTH-1:0] b_y,
	input  wire logic [COORD_WIDTH-1:0] b_z,
	input  wire logic [COORD_WIDTH-1:0] c_x,
	input  wire logic [COORD_WIDTH-1:0] c_y,
	input  wire logic [COORD_WIDTH-1:0] c_z,
	output logic                        empty,
	input  wire logic                   pop,
	output logic [COORD_WIDTH-1:0]      near_x,
	output logic [COORD_WIDTH-1:0]      near_y,
	output logic [COORD_WIDTH-1:0]      near_z,
	output logic [WEIGHT_FRAC_BITS:0]   weight_a,
	output logic [WEIGHT_FRAC_BITS:0]   weight_b,
	output logic [WEIGHT_FRAC_BITS:0]   weight_c,
	output logic [2:0]                  region,
	output logic                        degenerate
);

	localparam int CW     = COORD_WIDTH;
	localparam int DEN_W  = tcp_pkg::den_w(CW);
	localparam int CTL_W  = $bits(tcp_pkg::ctl_t);
	localparam int TRI_W  = 9 * CW;
	localparam int ITEM_W = CTL_W + TRI_W + 3 * DEN_W;

	// Queue word, from the top: control, vertices, numerators, divisor.
	localparam int OFS_DEN  = 0;
	localparam int OFS_NUM1 = DEN_W;
	localparam int OFS_NUM0 = 2 * DEN_W;
	localparam int OFS_TRI  = 3 * DEN_W;
	localparam int OFS_CTL  = 3 * DEN_W + TRI_W;

	logic              f_push, q_full, q_empty, b_pop;
	tcp_pkg::ctl_t     f_ctl, b_ctl;
	logic [TRI_W-1:0]  f_tri;
	logic [DEN_W-1:0]  f_num0, f_num1, f_den;
	logic [ITEM_W-1:0] q_wdata, q_rdata;

	tcp_front #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.a_x    (a_x),
		.a_y    (a_y),
		.a_z    (a_z),
		.b_x    (b_x),
		.b_y    (b_y),
		.b_z    (b_z),
		.c_x    (c_x),
		.c_y    (c_y),
		.c_z    (c_z),
		.q_push (f_push),
		.q_full (q_full),
		.q_ctl  (f_ctl),
		.q_tri  (f_tri),
		.q_num0 (f_num0),
		.q_num1 (f_num1),
		.q_den  (f_den)
	);

	assign q_wdata = {f_ctl, f_tri, f_num0, f_num1, f_den};

	tcp_fifo #(
		.WIDTH (ITEM_W),
		.DEPTH (tcp_pkg::QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (f_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.rd     (b_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	assign b_ctl = tcp_pkg::ctl_t'(q_rdata[OFS_CTL +: CTL_W]);

	tcp_back #(
		.COORD_WIDTH      (COORD_WIDTH),
		.WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_pop      (b_pop),
		.q_ctl      (b_ctl),
		.q_tri      (q_rdata[OFS_TRI +: TRI_W]),
		.q_num0     (q_rdata[OFS_NUM0 +: DEN_W]),
		.q_num1     (q_rdata[OFS_NUM1 +: DEN_W]),
		.q_den      (q_rdata[OFS_DEN +: DEN_W]),
		.empty      (empty),
		.pop        (pop),
		.near_x     (near_x),
		.near_y     (near_y),
		.near_z     (near_z),
		.weight_a   (weight_a),
		.weight_b   (weight_b),
		.weight_c   (weight_c),
		.region     (region),
		.degenerate (degenerate)
	);

endmodule

`default_nettype wire
